@@ hdl/rfc_pkg.sv @@
package rfc_pkg;

  localparam int DEF_STACK_DEPTH = 64;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int MAX_RESULTS     = 64;
  localparam int RANGE_BITS      = 16;
  localparam int MEAN_BITS       = 16;
  localparam int WEIGHT_BITS     = 8;
  localparam int STEP_BITS       = 16;
  localparam int CFG_BITS        = 16;
  localparam int CFG_IDX_BITS    = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_QUANT_STEP   = 2'd0,
    REG_CUTOFF_RANGE = 2'd1,
    REG_CYCLE_WEIGHT = 2'd2,
    REG_RESIDUE_MODE = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    PH_SAMPLE = 2'd0,
    PH_EOH    = 2'd1,
    PH_REPLAY = 2'd2
  } phase_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PUSH,
    S_CHECK,
    S_READ,
    S_TEST,
    S_DIV_R,
    S_DIV_M,
    S_MUL,
    S_CMP,
    S_EMIT,
    S_COLLAPSE,
    S_NEXT,
    S_RB_RD,
    S_RB_ADD,
    S_RP_RD,
    S_RP_PUSH,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [RANGE_BITS-1:0]       range_bin;
    logic signed [MEAN_BITS-1:0] mean_bin;
    logic [WEIGHT_BITS-1:0]      weight;
    logic                        overflow;
  } result_t;

endpackage

@@ hdl/rainflow_four_point_counter.sv @@
// Streaming four-point rainflow counter. Each input transaction carries one signed
// load sample; plateaus are dropped and the latest extreme is held until the signal
// reverses, when it is pushed onto a residue stack of STACK_DEPTH entries. After each
// push the top four stack points are read back one per cycle from the stack RAM and,
// while the inner two lie within the outer two, a cycle is counted and the pair is
// removed. Range and mean are rounded by one shared bit-serial divider, two divisions
// for each counted cycle, followed by one multiply for the cutoff test.
// The end-of-history sample flushes the pending peak and, with residue_mode set,
// doubles the residue through a second RAM and replays it, one point per step.
// A sample producing no result transaction produces no output at all; the final
// result of a sample carries last_result. Results wait in a one-entry holding register
// and an output register, so the block keeps working while the consumer stalls until
// both are full. No clearing pass follows reset; the block is ready right away.
module rainflow_four_point_counter import rfc_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_BITS-1:0]           cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_end_of_history,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [RANGE_BITS-1:0]         out_range_bin,
  output logic signed [MEAN_BITS-1:0]   out_mean_bin,
  output logic [WEIGHT_BITS-1:0]        out_weight,
  output logic                          out_overflow,
  output logic                          out_last_result
);

  localparam int SB  = SAMPLE_BITS;
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int CD  = 2 * STACK_DEPTH;
  localparam int CAW = $clog2(CD);
  localparam int CCW = $clog2(CD + 1);
  localparam int NW  = ((SB > STEP_BITS) ? SB : STEP_BITS) + 2;
  localparam int DW  = STEP_BITS + 1;
  localparam int PW  = NW + STEP_BITS;
  localparam int RNW = $clog2(MAX_RESULTS + 1);

  // Configuration registers.
  logic [STEP_BITS-1:0]   qstep_r;
  logic [STEP_BITS-1:0]   cutoff_r;
  logic [WEIGHT_BITS-1:0] cweight_r;
  logic                   rmode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qstep_r   <= STEP_BITS'(1);
      cutoff_r  <= '0;
      cweight_r <= WEIGHT_BITS'(1);
      rmode_r   <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_QUANT_STEP:   qstep_r   <= cfg_data[STEP_BITS-1:0];
        REG_CUTOFF_RANGE: cutoff_r  <= cfg_data[STEP_BITS-1:0];
        REG_CYCLE_WEIGHT: cweight_r <= cfg_data[WEIGHT_BITS-1:0];
        REG_RESIDUE_MODE: rmode_r   <= cfg_data[0];
        default:          rmode_r   <= rmode_r;
      endcase
    end
  end

  logic [STEP_BITS-1:0] step_eff;
  assign step_eff = (qstep_r == '0) ? STEP_BITS'(1) : qstep_r;

  // Sequencer and history state.
  state_t                 state_r, state_nxt;
  phase_t                 phase_r, phase_nxt;
  logic signed [SB-1:0]   prev_r, prev_nxt;
  logic                   hv_r, hv_nxt;
  logic signed [SB-1:0]   pend_r, pend_nxt;
  dir_t                   dir_r, dir_nxt;
  logic                   eoh_r, eoh_nxt;
  logic signed [SB-1:0]   pushv_r, pushv_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [CCW-1:0]         ccnt_r, ccnt_nxt;
  logic signed [SB-1:0]   cltop_r, cltop_nxt;
  logic signed [SB-1:0]   clsec_r, clsec_nxt;
  logic [CW-1:0]          rbi_r, rbi_nxt;
  logic                   round_r, round_nxt;
  logic [CCW-1:0]         rpj_r, rpj_nxt;
  logic [2:0]             rdk_r, rdk_nxt;
  logic signed [SB-1:0]   pv_r [4];
  logic signed [SB-1:0]   pv_nxt [4];
  logic [NW-1:0]          rbin_r, rbin_nxt;
  logic [NW-1:0]          mbin_r, mbin_nxt;
  logic [PW-1:0]          rnd_r, rnd_nxt;
  result_t                newres_r, newres_nxt;
  result_t                hold_r, hold_nxt;
  logic                   holdv_r, holdv_nxt;
  logic [RNW-1:0]         resn_r, resn_nxt;
  result_t                out_r, out_nxt;
  logic                   outlast_r, outlast_nxt;
  logic                   outv_r, outv_nxt;

  // Memory and divider hookups.
  logic                   rs_we;
  logic [AW-1:0]          rs_waddr, rs_raddr;
  logic [SB-1:0]          rs_wdata, rs_rdata;
  logic                   cs_we;
  logic [CAW-1:0]         cs_waddr, cs_raddr;
  logic [SB-1:0]          cs_wdata, cs_rdata;
  logic                   div_start, div_done;
  logic [NW-1:0]          div_num, div_q;
  logic [DW-1:0]          div_den;

  rfc_ram #(.DEPTH(STACK_DEPTH), .WIDTH(SB)) u_residue (
    .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
    .raddr(rs_raddr), .rdata(rs_rdata)
  );

  rfc_ram #(.DEPTH(CD), .WIDTH(SB)) u_closing (
    .clk(clk), .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
    .raddr(cs_raddr), .rdata(cs_rdata)
  );

  rfc_div #(.NW(NW), .DW(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_q)
  );

  // Arithmetic on the four stack points held in pv_r.
  logic signed [SB-1:0] inlo, inhi, outlo, outhi;
  logic                 fp_hit;
  logic signed [SB:0]   pdiff, psum;
  logic [SB-1:0]        pad;
  logic [SB:0]          pas;
  logic [NW-1:0]        rnum, mnum;
  logic [CW-1:0]        fp_addr;
  logic signed [SB-1:0] rb_v, rb_lo, rb_hi;
  logic                 slot_free;
  logic                 acc;
  dir_t                 sdir;

  always_comb begin
    inlo   = (pv_r[1] < pv_r[2]) ? pv_r[1] : pv_r[2];
    inhi   = (pv_r[1] < pv_r[2]) ? pv_r[2] : pv_r[1];
    outlo  = (pv_r[0] < pv_r[3]) ? pv_r[0] : pv_r[3];
    outhi  = (pv_r[0] < pv_r[3]) ? pv_r[3] : pv_r[0];
    fp_hit = (inlo >= outlo) && (inhi <= outhi);
    pdiff  = (SB+1)'(pv_r[1]) - (SB+1)'(pv_r[2]);
    psum   = (SB+1)'(pv_r[1]) + (SB+1)'(pv_r[2]);
    pad    = pdiff[SB] ? SB'(-pdiff) : pdiff[SB-1:0];
    pas    = psum[SB] ? (SB+1)'(-psum) : psum;
    rnum   = NW'({pad, 1'b0}) + NW'(step_eff);
    mnum   = NW'(pas) + NW'(step_eff);
    fp_addr = cnt_r - CW'(4) + CW'(rdk_r);
    rb_v   = signed'(rs_rdata);
    rb_lo  = (clsec_r < rb_v) ? clsec_r : rb_v;
    rb_hi  = (clsec_r < rb_v) ? rb_v : clsec_r;
    slot_free = !outv_r || out_ready;
    acc    = in_valid && (state_r == S_IDLE);
    sdir   = (in_sample > prev_r) ? DIR_UP : DIR_DOWN;
  end

  // Next state and datapath registers.
  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    prev_nxt   = prev_r;
    hv_nxt     = hv_r;
    pend_nxt   = pend_r;
    dir_nxt    = dir_r;
    eoh_nxt    = eoh_r;
    pushv_nxt  = pushv_r;
    cnt_nxt    = cnt_r;
    ccnt_nxt   = ccnt_r;
    cltop_nxt  = cltop_r;
    clsec_nxt  = clsec_r;
    rbi_nxt    = rbi_r;
    round_nxt  = round_r;
    rpj_nxt    = rpj_r;
    rdk_nxt    = rdk_r;
    pv_nxt     = pv_r;
    rbin_nxt   = rbin_r;
    mbin_nxt   = mbin_r;
    rnd_nxt    = rnd_r;
    newres_nxt = newres_r;
    hold_nxt   = hold_r;
    holdv_nxt  = holdv_r;
    resn_nxt   = resn_r;
    out_nxt    = out_r;
    outlast_nxt = outlast_r;
    outv_nxt   = out_ready ? 1'b0 : outv_r;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          resn_nxt  = '0;
          eoh_nxt   = in_end_of_history;
          phase_nxt = PH_SAMPLE;
          state_nxt = S_NEXT;
          prev_nxt  = in_sample;
          hv_nxt    = 1'b1;
          if (!hv_r) begin
            pend_nxt = in_sample;
            dir_nxt  = DIR_NONE;
          end else if (in_sample != prev_r) begin
            // A reversal (or the first move) turns the held extreme into a point.
            if (dir_r == DIR_NONE || sdir != dir_r) begin
              pushv_nxt = pend_r;
              state_nxt = S_PUSH;
            end
            pend_nxt = in_sample;
            dir_nxt  = sdir;
          end
        end
      end
      S_PUSH: begin
        if (cnt_r >= CW'(STACK_DEPTH)) begin
          newres_nxt = '{range_bin: '0, mean_bin: '0, weight: '0, overflow: 1'b1};
          state_nxt  = S_EMIT;
        end else begin
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        rdk_nxt   = '0;
        state_nxt = (cnt_r < CW'(4)) ? S_NEXT : S_READ;
      end
      S_READ: begin
        if (rdk_r != 3'd0) begin
          pv_nxt[rdk_r[1:0] - 2'd1] = signed'(rs_rdata);
        end
        rdk_nxt = rdk_r + 3'd1;
        if (rdk_r == 3'd4) begin
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        state_nxt = fp_hit ? S_DIV_R : S_NEXT;
      end
      S_DIV_R: begin
        if (div_done) begin
          rbin_nxt  = div_q;
          state_nxt = S_DIV_M;
        end
      end
      S_DIV_M: begin
        if (div_done) begin
          mbin_nxt  = div_q;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        rnd_nxt   = PW'(rbin_r) * PW'(step_eff);
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (rnd_r == '0 || rnd_r < PW'(cutoff_r)) begin
          state_nxt = S_COLLAPSE;
        end else begin
          newres_nxt.range_bin = rbin_r[RANGE_BITS-1:0];
          newres_nxt.mean_bin  = psum[SB] ? MEAN_BITS'(-mbin_r) : mbin_r[MEAN_BITS-1:0];
          newres_nxt.weight    = cweight_r;
          newres_nxt.overflow  = 1'b0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // The newest result waits in the holding register until the next one
        // or the end of the transaction tells whether it is the last.
        if (resn_r >= RNW'(MAX_RESULTS)) begin
          state_nxt = newres_r.overflow ? S_NEXT : S_COLLAPSE;
        end else if (!holdv_r) begin
          hold_nxt  = newres_r;
          holdv_nxt = 1'b1;
          resn_nxt  = resn_r + RNW'(1);
          state_nxt = newres_r.overflow ? S_NEXT : S_COLLAPSE;
        end else if (slot_free) begin
          out_nxt     = hold_r;
          outlast_nxt = 1'b0;
          outv_nxt    = 1'b1;
          hold_nxt    = newres_r;
          resn_nxt    = resn_r + RNW'(1);
          state_nxt   = newres_r.overflow ? S_NEXT : S_COLLAPSE;
        end
      end
      S_COLLAPSE: begin
        cnt_nxt   = cnt_r - CW'(2);
        state_nxt = S_CHECK;
      end
      S_NEXT: begin
        case (phase_r)
          PH_SAMPLE: begin
            if (eoh_r) begin
              pushv_nxt = pend_r;
              phase_nxt = PH_EOH;
              state_nxt = S_PUSH;
            end else begin
              state_nxt = S_FLUSH;
            end
          end
          PH_EOH: begin
            ccnt_nxt  = '0;
            rbi_nxt   = '0;
            round_nxt = 1'b0;
            state_nxt = (rmode_r && cnt_r != '0) ? S_RB_RD : S_FLUSH;
          end
          PH_REPLAY: begin
            if (rpj_r + CCW'(1) < ccnt_r) begin
              rpj_nxt   = rpj_r + CCW'(1);
              state_nxt = S_RP_RD;
            end else begin
              state_nxt = S_FLUSH;
            end
          end
          default: state_nxt = S_FLUSH;
        endcase
      end
      S_RB_RD: begin
        state_nxt = S_RB_ADD;
      end
      S_RB_ADD: begin
        // Reduce the doubled residue to turning points as it is copied.
        if (ccnt_r != '0 && cltop_r == rb_v) begin
          ccnt_nxt = ccnt_r;
        end else if (ccnt_r >= CCW'(2) && cltop_r >= rb_lo && cltop_r <= rb_hi) begin
          cltop_nxt = rb_v;
        end else if (ccnt_r < CCW'(CD)) begin
          clsec_nxt = cltop_r;
          cltop_nxt = rb_v;
          ccnt_nxt  = ccnt_r + CCW'(1);
        end
        rbi_nxt   = rbi_r + CW'(1);
        state_nxt = S_RB_RD;
        if (rbi_r + CW'(1) == cnt_r) begin
          if (!round_r) begin
            round_nxt = 1'b1;
            rbi_nxt   = '0;
          end else begin
            cnt_nxt   = '0;
            rpj_nxt   = '0;
            phase_nxt = PH_REPLAY;
            state_nxt = S_RP_RD;
          end
        end
      end
      S_RP_RD: begin
        state_nxt = S_RP_PUSH;
      end
      S_RP_PUSH: begin
        pushv_nxt = signed'(cs_rdata);
        state_nxt = S_PUSH;
      end
      S_FLUSH: begin
        if (!holdv_r || slot_free) begin
          if (holdv_r) begin
            out_nxt     = hold_r;
            outlast_nxt = 1'b1;
            outv_nxt    = 1'b1;
            holdv_nxt   = 1'b0;
          end
          if (eoh_r) begin
            prev_nxt = '0;
            hv_nxt   = 1'b0;
            pend_nxt = '0;
            dir_nxt  = DIR_NONE;
            cnt_nxt  = '0;
            ccnt_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Handshake, memory and divider controls.
  always_comb begin
    in_ready  = (state_r == S_IDLE);
    rs_we     = 1'b0;
    rs_waddr  = cnt_r[AW-1:0];
    rs_wdata  = pushv_r;
    rs_raddr  = (state_r == S_READ) ? fp_addr[AW-1:0] : rbi_r[AW-1:0];
    cs_we     = 1'b0;
    cs_waddr  = ccnt_r[CAW-1:0];
    cs_wdata  = rb_v;
    cs_raddr  = rpj_r[CAW-1:0];
    div_start = 1'b0;
    div_num   = rnum;
    div_den   = {step_eff, 1'b0};
    case (state_r)
      S_PUSH: begin
        rs_we = (cnt_r < CW'(STACK_DEPTH));
      end
      S_COLLAPSE: begin
        rs_we    = 1'b1;
        rs_waddr = AW'(cnt_r - CW'(3));
        rs_wdata = pv_r[3];
      end
      S_TEST: begin
        div_start = fp_hit;
      end
      S_DIV_R: begin
        div_start = div_done;
        div_num   = mnum;
      end
      S_RB_ADD: begin
        if (ccnt_r != '0 && cltop_r == rb_v) begin
          cs_we = 1'b0;
        end else if (ccnt_r >= CCW'(2) && cltop_r >= rb_lo && cltop_r <= rb_hi) begin
          cs_we    = 1'b1;
          cs_waddr = CAW'(ccnt_r - CCW'(1));
        end else begin
          cs_we = (ccnt_r < CCW'(CD));
        end
      end
      default: begin
        rs_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      phase_r   <= PH_SAMPLE;
      prev_r    <= '0;
      hv_r      <= 1'b0;
      pend_r    <= '0;
      dir_r     <= DIR_NONE;
      eoh_r     <= 1'b0;
      cnt_r     <= '0;
      ccnt_r    <= '0;
      holdv_r   <= 1'b0;
      resn_r    <= '0;
      outv_r    <= 1'b0;
      rdk_r     <= '0;
      round_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      prev_r    <= prev_nxt;
      hv_r      <= hv_nxt;
      pend_r    <= pend_nxt;
      dir_r     <= dir_nxt;
      eoh_r     <= eoh_nxt;
      cnt_r     <= cnt_nxt;
      ccnt_r    <= ccnt_nxt;
      holdv_r   <= holdv_nxt;
      resn_r    <= resn_nxt;
      outv_r    <= outv_nxt;
      rdk_r     <= rdk_nxt;
      round_r   <= round_nxt;
    end
    pushv_r   <= pushv_nxt;
    cltop_r   <= cltop_nxt;
    clsec_r   <= clsec_nxt;
    rbi_r     <= rbi_nxt;
    rpj_r     <= rpj_nxt;
    pv_r      <= pv_nxt;
    rbin_r    <= rbin_nxt;
    mbin_r    <= mbin_nxt;
    rnd_r     <= rnd_nxt;
    newres_r  <= newres_nxt;
    hold_r    <= hold_nxt;
    out_r     <= out_nxt;
    outlast_r <= outlast_nxt;
  end

  assign out_valid       = outv_r;
  assign out_range_bin   = out_r.range_bin;
  assign out_mean_bin    = out_r.mean_bin;
  assign out_weight      = out_r.weight;
  assign out_overflow    = out_r.overflow;
  assign out_last_result = outlast_r;

endmodule

@@ hdl/rfc_ram.sv @@
module rfc_ram import rfc_pkg::*; #(
  parameter int DEPTH = DEF_STACK_DEPTH,
  parameter int WIDTH = DEF_SAMPLE_BITS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/rfc_div.sv @@
// Restoring divider, one quotient bit per cycle.
module rfc_div import rfc_pkg::*; #(
  parameter int NW = DEF_SAMPLE_BITS + 2,
  parameter int DW = STEP_BITS + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);

  localparam int CNW = $clog2(NW + 1);

  logic [DW-1:0]  rem_r, rem_nxt;
  logic [DW-1:0]  den_r, den_nxt;
  logic [NW-1:0]  num_r, num_nxt;
  logic [NW-1:0]  q_r, q_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [DW:0]    trial;
  logic           qbit;

  always_comb begin
    trial    = {rem_r, num_r[NW-1]};
    qbit     = (trial >= {1'b0, den_r});
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    num_nxt  = num_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      den_nxt  = den;
      num_nxt  = num;
      q_nxt    = '0;
      cnt_nxt  = CNW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = qbit ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      q_nxt   = {q_r[NW-2:0], qbit};
      num_nxt = {num_r[NW-2:0], 1'b0};
      cnt_nxt = cnt_r - CNW'(1);
      if (cnt_r == CNW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    num_r <= num_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

@@ hdl/rfc_checker.sv @@
module rfc_checker import rfc_pkg::*; (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [RANGE_BITS-1:0]       out_range_bin,
  input logic signed [MEAN_BITS-1:0] out_mean_bin,
  input logic [WEIGHT_BITS-1:0]      out_weight,
  input logic                        out_overflow,
  input logic                        out_last_result
);

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready after accepting a transaction");

  a_overflow_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_weight == '0 && out_range_bin == '0
                                  && out_mean_bin == '0)
    else $error("overflow result with nonzero fields");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_range_bin)
      && $stable(out_mean_bin) && $stable(out_last_result))
    else $error("stalled result changed");

endmodule

bind rainflow_four_point_counter rfc_checker u_rfc_checker (.*);
